// ===== src/image_resample_2x2_average_core_assert.svh =====
// ----------------------------------------------------------------------------
// image_resample_2x2_average_core_assert.svh
// assertion macros shared by the resampler rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef IMAGE_RESAMPLE_2X2_AVERAGE_CORE_ASSERT_SVH
`define IMAGE_RESAMPLE_2X2_AVERAGE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IRA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define IRA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IRA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define IRA_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg
// shared constants and types of the 2x2 box-filter resampler
// ----------------------------------------------------------------------------
package ira_pkg;

  // pixel memory
  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_W     = 16;
  localparam int PIX_W      = 32;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;

  // image sizes
  localparam int MAX_DIMENSION = 4096;
  localparam int SIZE_W        = 13;
  localparam int COORD_W       = 12;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

  // request opcodes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // shared divider, two quotient bits per cycle
  localparam int DIV_NUM_W = 30;
  localparam int DIV_DEN_W = 15;
  localparam int DIV_STEPS = DIV_NUM_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== src/ira_req_if.sv =====
// ----------------------------------------------------------------------------
// ira_req_if
// input channel: pixel writes and output pixel requests
// ----------------------------------------------------------------------------
interface ira_req_if import ira_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [ADDR_W-1:0]  pixel_index;
  logic [PIX_W-1:0]   pixel_value;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  modport source (output valid, opcode, pixel_index, pixel_value, out_x, out_y,
                  input ready);
  modport sink   (input valid, opcode, pixel_index, pixel_value, out_x, out_y,
                  output ready);
endinterface

// ===== src/ira_pix_if.sv =====
// ----------------------------------------------------------------------------
// ira_pix_if
// result channel: one averaged rgba pixel
// ----------------------------------------------------------------------------
interface ira_pix_if import ira_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel_0;
  logic [CHAN_W-1:0] channel_1;
  logic [CHAN_W-1:0] channel_2;
  logic [CHAN_W-1:0] channel_3;

  modport source (output valid, channel_0, channel_1, channel_2, channel_3,
                  input ready);
  modport sink   (input valid, channel_0, channel_1, channel_2, channel_3,
                  output ready);
endinterface

// ===== src/image_resample_2x2_average_core.sv =====
// Sequence: the first request after reset or a configuration write runs the step division
// before the row divisions; later requests reuse the stored step.
// Throughput: writes one per cycle while no request is in progress; one request at a time,
// each running two row divisions (product, start, 15 divider steps, done) in the shared
// divider plus four pixel memory reads; a stalled receiver adds its stall on top.
// Reset: synchronous; sizes return to 1, pixel memory contents stay undefined.
// ----------------------------------------------------------------------------
// image_resample_2x2_average_core
// 2x2 box-filter image resampler over a source rgba pixel memory
// ----------------------------------------------------------------------------
`include "image_resample_2x2_average_core_assert.svh"

module image_resample_2x2_average_core import ira_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  ira_req_if.sink              req,
  ira_pix_if.source            rsp
);

  localparam int MUL_A_W  = 29;
  localparam int MUL_B_W  = 16;
  localparam int MUL_W    = MUL_A_W + MUL_B_W;
  localparam int PROD_W   = 41;
  localparam int STEP_W   = 29;
  localparam int ACC_W    = CHAN_W + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_STEP_GO, S_STEP_WAIT,
    S_RA_MUL, S_RA_GO, S_RA_WAIT,
    S_RB_MUL, S_RB_GO, S_RB_WAIT,
    S_BASE_MUL, S_COL,
    S_ADDR_A, S_RD0, S_RD1, S_ADDR_B, S_RD2, S_RD3, S_SUM, S_OUT
  } state_t;

  // out-of-range sizes: zero acts as one, large values saturate
  function automatic logic [SIZE_W-1:0] size_used(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_DIMENSION)) begin
      r = SIZE_W'(MAX_DIMENSION);
    end else begin
      r = v;
    end
    return r;
  endfunction

  state_t state;

  logic [SIZE_W-1:0] in_width, in_height, out_width, out_height;
  logic [SIZE_W-1:0] iw, ih, ow, oh;
  logic              step_ok;
  logic              out_valid;
  logic              out_load;
  logic              div_wait;

  logic [COORD_W-1:0] x, y;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-2:0]  step3q;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  row_a, row_b, col_a, col_b;
  logic [ACC_W-1:0]   acc [NUM_CHAN];
  logic [CHAN_W-1:0]  chan [NUM_CHAN];

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_full;
  logic [PROD_W-1:0]  sum_a, sum_b;

  logic              req_xfer, wr_xfer, rq_xfer;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign iw = size_used(in_width);
  assign ih = size_used(in_height);
  assign ow = size_used(out_width);
  assign oh = size_used(out_height);

  // input handshake
  assign req.ready = (state == S_IDLE) && !rst;
  assign req_xfer  = req.valid && req.ready;
  assign wr_xfer   = req_xfer && (req.opcode == OP_WRITE);
  assign rq_xfer   = req_xfer && (req.opcode == OP_REQUEST);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= SIZE_W'(1);
      in_height  <= SIZE_W'(1);
      out_width  <= SIZE_W'(1);
      out_height <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_WIDTH:   in_width   <= cfg_data;
        REG_IN_HEIGHT:  in_height  <= cfg_data;
        REG_OUT_WIDTH:  out_width  <= cfg_data;
        REG_OUT_HEIGHT: out_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // divider operands
  always_comb begin
    div_req.start = (state == S_STEP_GO) || (state == S_RA_GO) || (state == S_RB_GO);
    if (state == S_STEP_GO) begin
      div_req.num = {1'b0, iw, 16'h0000};
      div_req.den = {2'b00, ow};
    end else begin
      div_req.num = prod[DIV_NUM_W-1:0];
      div_req.den = {oh, 2'b00};
    end
  end

  ira_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RA_MUL: begin
        mul_a = {15'd0, y, 2'b01};
        mul_b = {3'd0, ih};
      end
      S_RB_MUL: begin
        mul_a = {15'd0, y, 2'b11};
        mul_b = {3'd0, ih};
      end
      S_BASE_MUL: begin
        mul_a = step;
        mul_b = {4'd0, x};
      end
      S_ADDR_A: begin
        mul_a = {13'd0, row_a};
        mul_b = {3'd0, iw};
      end
      S_ADDR_B: begin
        mul_a = {13'd0, row_b};
        mul_b = {3'd0, iw};
      end
      default: ;
    endcase
  end

  assign mul_full = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // column positions: quarter and three-quarter offsets on x*step
  assign sum_a = {14'd0, step[STEP_W-1:2]} + prod;
  assign sum_b = {13'd0, step3q} + prod;

  // pixel memory reads
  assign rd_en   = (state == S_RD0) || (state == S_RD1) ||
                   (state == S_RD2) || (state == S_RD3);
  assign rd_addr = prod[ADDR_W-1:0] +
                   (((state == S_RD0) || (state == S_RD2)) ? col_a : col_b);

  ira_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_mem (
    .clk   (clk),
    .we    (wr_xfer),
    .waddr (req.pixel_index),
    .wdata (req.pixel_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (rq_xfer) begin
      x <= req.out_x;
      y <= req.out_y;
    end
    if ((state == S_STEP_WAIT) && div_rsp.done) begin
      step <= div_rsp.quo[STEP_W-1:0];
    end
    if ((state == S_RA_WAIT) && div_rsp.done) begin
      row_a <= div_rsp.quo[ADDR_W-1:0];
    end
    if ((state == S_RB_WAIT) && div_rsp.done) begin
      row_b <= div_rsp.quo[ADDR_W-1:0];
    end
    if ((state == S_RA_MUL) || (state == S_RB_MUL) || (state == S_BASE_MUL) ||
        (state == S_ADDR_A) || (state == S_ADDR_B)) begin
      prod <= mul_full[PROD_W-1:0];
    end
    if (state == S_BASE_MUL) begin
      step3q <= {1'b0, step[STEP_W-1:2]} + {step[STEP_W-1:2], 1'b0};
    end
    if (state == S_COL) begin
      col_a <= sum_a[ADDR_W+15:16];
      col_b <= sum_b[ADDR_W+15:16];
    end
    // per-channel sums of the four pixels
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (state == S_RD1) begin
        acc[c] <= {2'b00, rd_data[c*CHAN_W +: CHAN_W]};
      end else if ((state == S_ADDR_B) || (state == S_RD3) || (state == S_SUM)) begin
        acc[c] <= acc[c] + {2'b00, rd_data[c*CHAN_W +: CHAN_W]};
      end
    end
  end

  // result register loads when it is free or drains in the same cycle
  assign out_load = (state == S_OUT) && (!out_valid || rsp.ready);
  assign div_wait = (state == S_STEP_WAIT) || (state == S_RA_WAIT) || (state == S_RB_WAIT);

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_ok   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        step_ok <= 1'b0;
      end else if ((state == S_STEP_WAIT) && div_rsp.done) begin
        step_ok <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (rq_xfer) begin
            state <= step_ok ? S_RA_MUL : S_STEP_GO;
          end
        end
        S_STEP_GO:   state <= S_STEP_WAIT;
        S_STEP_WAIT: begin
          if (div_rsp.done) begin
            state <= S_RA_MUL;
          end
        end
        S_RA_MUL:  state <= S_RA_GO;
        S_RA_GO:   state <= S_RA_WAIT;
        S_RA_WAIT: begin
          if (div_rsp.done) begin
            state <= S_RB_MUL;
          end
        end
        S_RB_MUL:  state <= S_RB_GO;
        S_RB_GO:   state <= S_RB_WAIT;
        S_RB_WAIT: begin
          if (div_rsp.done) begin
            state <= S_BASE_MUL;
          end
        end
        S_BASE_MUL: state <= S_COL;
        S_COL:      state <= S_ADDR_A;
        S_ADDR_A:   state <= S_RD0;
        S_RD0:      state <= S_RD1;
        S_RD1:      state <= S_ADDR_B;
        S_ADDR_B:   state <= S_RD2;
        S_RD2:      state <= S_RD3;
        S_RD3:      state <= S_SUM;
        S_SUM:      state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
              chan[c] <= acc[c][ACC_W-1:2];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.channel_0 = chan[0];
  assign rsp.channel_1 = chan[1];
  assign rsp.channel_2 = chan[2];
  assign rsp.channel_3 = chan[3];

  `IRA_ASSERT_IMP(a_done_in_wait, clk, rst, div_rsp.done, div_wait, "divider done outside wait")
  `IRA_ASSERT_NXT(a_cfg_drops_step, clk, rst, cfg_we, !step_ok, "step kept after config write")
  `IRA_ASSERT_NXT(a_out_load, clk, rst, out_load, rsp.valid && state == S_IDLE, "no result")

endmodule

// ===== src/ira_ram.sv =====
// ----------------------------------------------------------------------------
// ira_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ira_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ira_div.sv =====
// ----------------------------------------------------------------------------
// ira_div
// shared restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
`include "image_resample_2x2_average_core_assert.svh"

module ira_div import ira_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int REM_W = DIV_DEN_W + 1;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W-1:0]     rem;
  logic [DIV_NUM_W-1:0] qr;
  logic [DIV_DEN_W-1:0] den_r;

  logic [REM_W:0]   r1, r2, d_ext;
  logic             q1, q2;
  logic [REM_W-1:0] rem1, rem2;

  // two dependent restoring steps
  always_comb begin
    d_ext = {2'b00, den_r};
    r1    = {rem, qr[DIV_NUM_W-1]};
    q1    = (r1 >= d_ext);
    rem1  = q1 ? REM_W'(r1 - d_ext) : REM_W'(r1);
    r2    = {rem1, qr[DIV_NUM_W-2]};
    q2    = (r2 >= d_ext);
    rem2  = q2 ? REM_W'(r2 - d_ext) : REM_W'(r2);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      qr    <= req.num;
      rem   <= '0;
      den_r <= req.den;
    end else if (busy) begin
      qr  <= {qr[DIV_NUM_W-3:0], q1, q2};
      rem <= rem2;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = qr;

  `IRA_ASSERT_IMP(a_div_start_idle, clk, rst, req.start, !busy, "divider started while busy")
  `IRA_ASSERT_NXT(a_div_finish, clk, rst, busy && !req.start && cnt == DIV_CNT_W'(DIV_STEPS - 1), done && !busy, "divider did not finish")

endmodule
